>>> rtl/ipv6p_pkg.sv
package ipv6p_pkg;

  localparam logic [3:0] GROUPS = 4'd8;
  localparam logic [2:0] MAX_DIGITS = 3'd4;
  localparam logic [3:0] LETTER_OFFSET = 4'd9;

  localparam logic [7:0] CHAR_COLON   = 8'h3a;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_F = 8'h66;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_F = 8'h46;

  typedef struct packed {
    logic [7:0] character;
    logic       is_last;
  } in_t;

  typedef struct packed {
    logic        parse_ok;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
  } out_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_t;

  typedef struct packed {
    logic             failed;
    logic [3:0]       groups_written;
    logic             gap_seen;
    logic [3:0]       gap_position;
    logic [7:0][15:0] groups;
  } view_t;

  function automatic hex_t hex_value(logic [7:0] c);
    hex_t h;
    h.valid = 1'b1;
    h.value = 4'd0;
    priority if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      h.value = c[3:0];
    end else if ((c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) ||
                 (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F)) begin
      h.value = c[3:0] + LETTER_OFFSET;
    end else begin
      h.valid = 1'b0;
    end
    return h;
  endfunction

endpackage

>>> rtl/ipv6p_input_stage.sv
module ipv6p_input_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            request_valid,
  output logic            request_stall,
  input  ipv6p_pkg::in_t  request,
  input  logic            drain_ok,
  output logic            advance,
  output ipv6p_pkg::in_t  item
);

  logic item_valid;

  assign advance       = item_valid && (!item.is_last || drain_ok);
  assign request_stall = item_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!request_stall) begin
      item_valid <= request_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!request_stall && request_valid) begin
      item <= request;
    end
  end

endmodule

>>> rtl/ipv6p_parser.sv
module ipv6p_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  ipv6p_pkg::in_t   item,
  output ipv6p_pkg::view_t view
);

  logic [7:0][15:0] store;
  logic [3:0]       groups_written;
  logic [3:0]       gap_position;
  logic             gap_seen;
  logic [15:0]      group_value;
  logic [2:0]       digit_count;
  logic             failed;
  logic             at_start;
  logic             leading_colon;

  logic [7:0][15:0] store_next;
  logic [3:0]       groups_written_next;
  logic [3:0]       gap_position_next;
  logic             gap_seen_next;
  logic [15:0]      group_value_next;
  logic [2:0]       digit_count_next;
  logic             failed_next;
  logic             at_start_next;
  logic             leading_colon_next;

  ipv6p_pkg::hex_t hv;
  logic            is_colon;
  logic            take;
  logic            close;

  always_comb begin
    hv       = ipv6p_pkg::hex_value(item.character);
    is_colon = item.character == ipv6p_pkg::CHAR_COLON;

    store_next          = store;
    groups_written_next = groups_written;
    gap_position_next   = gap_position;
    gap_seen_next       = gap_seen;
    group_value_next    = group_value;
    digit_count_next    = digit_count;
    failed_next         = failed;
    at_start_next       = at_start;
    leading_colon_next  = leading_colon;
    take                = 1'b0;
    close               = 1'b0;

    if (!failed) begin
      priority if (at_start) begin
        at_start_next = 1'b0;
        if (is_colon) begin
          if (item.is_last) begin
            failed_next = 1'b1;
          end else begin
            leading_colon_next = 1'b1;
          end
        end else begin
          take = 1'b1;
        end
      end else if (leading_colon) begin
        leading_colon_next = 1'b0;
        if (!is_colon) begin
          failed_next = 1'b1;
        end else begin
          take = 1'b1;
        end
      end else begin
        take = 1'b1;
      end
    end

    if (take) begin
      priority if (hv.valid) begin
        group_value_next = {group_value[11:0], hv.value};
        digit_count_next = digit_count + 3'd1;
        if (digit_count_next > ipv6p_pkg::MAX_DIGITS) begin
          failed_next = 1'b1;
        end
      end else if (is_colon) begin
        priority if (digit_count == 3'd0) begin
          if (gap_seen) begin
            failed_next = 1'b1;
          end else begin
            gap_seen_next     = 1'b1;
            gap_position_next = groups_written;
          end
        end else if (item.is_last || groups_written >= ipv6p_pkg::GROUPS) begin
          failed_next = 1'b1;
        end else begin
          close = 1'b1;
        end
      end else begin
        failed_next = 1'b1;
      end
    end

    // flush a pending group on the final character
    if (item.is_last && !failed_next && digit_count_next != 3'd0) begin
      if (groups_written_next >= ipv6p_pkg::GROUPS) begin
        failed_next = 1'b1;
      end else begin
        close = 1'b1;
      end
    end

    if (close) begin
      store_next[groups_written_next[2:0]] = group_value_next;
      groups_written_next = groups_written_next + 4'd1;
      group_value_next    = 16'd0;
      digit_count_next    = 3'd0;
    end

    if (item.is_last && !failed_next) begin
      if (gap_seen_next) begin
        if (groups_written_next >= ipv6p_pkg::GROUPS) begin
          failed_next = 1'b1;
        end
      end else if (groups_written_next != ipv6p_pkg::GROUPS) begin
        failed_next = 1'b1;
      end
    end

    view.failed         = failed_next;
    view.groups_written = groups_written_next;
    view.gap_seen       = gap_seen_next;
    view.gap_position   = gap_position_next;
    view.groups         = store_next;

    // restart for the next text
    if (item.is_last) begin
      groups_written_next = 4'd0;
      gap_position_next   = 4'd0;
      gap_seen_next       = 1'b0;
      group_value_next    = 16'd0;
      digit_count_next    = 3'd0;
      failed_next         = 1'b0;
      at_start_next       = 1'b1;
      leading_colon_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      groups_written <= 4'd0;
      gap_position   <= 4'd0;
      gap_seen       <= 1'b0;
      group_value    <= 16'd0;
      digit_count    <= 3'd0;
      failed         <= 1'b0;
      at_start       <= 1'b1;
      leading_colon  <= 1'b0;
    end else if (advance) begin
      groups_written <= groups_written_next;
      gap_position   <= gap_position_next;
      gap_seen       <= gap_seen_next;
      group_value    <= group_value_next;
      digit_count    <= digit_count_next;
      failed         <= failed_next;
      at_start       <= at_start_next;
      leading_colon  <= leading_colon_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      store <= store_next;
    end
  end

  a_groups_bound: assert property (@(posedge clk) disable iff (rst)
    groups_written <= ipv6p_pkg::GROUPS)
    else $error("group count past eight");

  a_digits_bound: assert property (@(posedge clk) disable iff (rst)
    !failed |-> digit_count <= ipv6p_pkg::MAX_DIGITS)
    else $error("too many digits without failure");

  a_gap_order: assert property (@(posedge clk) disable iff (rst)
    gap_seen |-> gap_position <= groups_written)
    else $error("gap beyond written groups");

endmodule

>>> rtl/ipv6p_assembler.sv
module ipv6p_assembler (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  ipv6p_pkg::in_t   item,
  input  ipv6p_pkg::view_t view,
  output logic             drain_ok,
  output logic             result_valid,
  input  logic             result_stall,
  output ipv6p_pkg::out_t  result
);

  logic [7:0][15:0] final_groups;
  logic [3:0]       gap_start;
  logic [3:0]       zeros;
  logic [4:0]       gap_end;
  logic [3:0]       idx;
  logic [3:0]       src;
  ipv6p_pkg::out_t  result_next;
  logic             capture;

  assign drain_ok = !result_valid || !result_stall;
  assign capture  = advance && item.is_last;

  always_comb begin
    gap_start = view.gap_seen ? view.gap_position : ipv6p_pkg::GROUPS;
    zeros     = ipv6p_pkg::GROUPS - view.groups_written;
    gap_end   = {1'b0, gap_start} + {1'b0, zeros};
    idx       = 4'd0;
    src       = 4'd0;
    for (int i = 0; i < 8; i++) begin
      idx = 4'(i);
      src = idx - zeros;
      priority if (idx < gap_start) begin
        final_groups[7 - i] = view.groups[i];
      end else if ({1'b0, idx} < gap_end) begin
        final_groups[7 - i] = 16'd0;
      end else begin
        final_groups[7 - i] = view.groups[src[2:0]];
      end
    end

    result_next.parse_ok  = !view.failed;
    result_next.addr_high = view.failed ? 64'd0 : final_groups[7:4];
    result_next.addr_low  = view.failed ? 64'd0 : final_groups[3:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (capture) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      result <= result_next;
    end
  end

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.parse_ok |-> result.addr_high == 64'd0 &&
                                         result.addr_low == 64'd0)
    else $error("failed parse with nonzero address");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |-> !capture)
    else $error("result overwritten while stalled");

  a_capture_shows: assert property (@(posedge clk) disable iff (rst)
    capture |=> result_valid)
    else $error("captured result not presented");

endmodule

>>> rtl/ipv6_text_address_parser.sv
// channel   dir  payload            handshake
// request   in   ipv6p_pkg::in_t    request_valid / request_stall
// result    out  ipv6p_pkg::out_t   result_valid  / result_stall
//
// One character per cycle unless request_stall is high; the result register
// loads at the edge where the final character leaves the input register.
// Rate is set by the character step in the parser state update.
// rst is synchronous and restarts the parser at the start of a text.
// A stalled result holds only a final character; other characters keep flowing.
module ipv6_text_address_parser (
  input  logic            clk,
  input  logic            rst,
  input  logic            request_valid,
  output logic            request_stall,
  input  ipv6p_pkg::in_t  request,
  output logic            result_valid,
  input  logic            result_stall,
  output ipv6p_pkg::out_t result
);

  ipv6p_pkg::in_t   item;
  ipv6p_pkg::view_t view;
  logic             advance;
  logic             drain_ok;

  ipv6p_input_stage u_input (
    .clk           (clk),
    .rst           (rst),
    .request_valid (request_valid),
    .request_stall (request_stall),
    .request       (request),
    .drain_ok      (drain_ok),
    .advance       (advance),
    .item          (item)
  );

  ipv6p_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (item),
    .view    (view)
  );

  ipv6p_assembler u_assembler (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .item         (item),
    .view         (view),
    .drain_ok     (drain_ok),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

>>> sim/testbench.sv
module testbench;

  localparam int CYCLE_LIMIT = 400000;
  localparam int TARGET_CHARS = 900;
  localparam int DRAIN_CYCLES = 8;

  typedef struct {
    logic [7:0] ch;
    logic       last;
    logic       typed;
    logic       ok;
  } row_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             request_valid;
  logic             request_stall;
  ipv6p_pkg::in_t   request;
  logic             result_valid;
  logic             result_stall;
  ipv6p_pkg::out_t  result;

  ipv6p_pkg::out_t pending_addrs[$];
  logic [7:0]      text_chars[$];
  row_t            directed_rows [24];
  int              mismatch_count = 0;
  int              cycle_count = 0;

  logic [15:0] p_groups [8];
  logic [3:0]  p_count;
  logic [3:0]  p_gap_pos;
  logic        p_gap;
  logic [15:0] p_acc;
  logic [2:0]  p_digits;
  logic        p_failed;
  logic        p_start;
  logic        p_lead;

  ipv6_text_address_parser u_dut (
    .clk           (clk),
    .rst           (rst),
    .request_valid (request_valid),
    .request_stall (request_stall),
    .request       (request),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result        (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic int hex_digit_of(logic [7:0] c);
    if (c >= ipv6p_pkg::CHAR_ZERO && c <= ipv6p_pkg::CHAR_NINE)
      return int'(c - ipv6p_pkg::CHAR_ZERO);
    if (c >= ipv6p_pkg::CHAR_LOWER_A && c <= ipv6p_pkg::CHAR_LOWER_F)
      return int'(c - ipv6p_pkg::CHAR_LOWER_A) + 10;
    if (c >= ipv6p_pkg::CHAR_UPPER_A && c <= ipv6p_pkg::CHAR_UPPER_F)
      return int'(c - ipv6p_pkg::CHAR_UPPER_A) + 10;
    return -1;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] d);
    if (d < 4'd10) return ipv6p_pkg::CHAR_ZERO + 8'(d);
    if ($urandom_range(0, 1) == 0) return ipv6p_pkg::CHAR_LOWER_A + 8'(d - 4'd10);
    return ipv6p_pkg::CHAR_UPPER_A + 8'(d - 4'd10);
  endfunction

  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic clear_parse();
    for (int i = 0; i < 8; i++) p_groups[i] = 16'h0;
    p_count = 4'd0;
    p_gap_pos = 4'd0;
    p_gap = 1'b0;
    p_acc = 16'h0;
    p_digits = 3'd0;
    p_failed = 1'b0;
    p_start = 1'b1;
    p_lead = 1'b0;
  endtask

  task automatic close_group();
    p_groups[p_count[2:0]] = p_acc;
    p_count = p_count + 4'd1;
    p_acc = 16'h0;
    p_digits = 3'd0;
  endtask

  task automatic absorb_char(logic [7:0] c, logic last);
    int v;
    v = hex_digit_of(c);
    if (v >= 0) begin
      p_acc = {p_acc[11:0], 4'(v)};
      p_digits = p_digits + 3'd1;
      if (p_digits > ipv6p_pkg::MAX_DIGITS) p_failed = 1'b1;
    end else if (c == ipv6p_pkg::CHAR_COLON) begin
      if (p_digits == 3'd0) begin
        if (p_gap) begin
          p_failed = 1'b1;
        end else begin
          p_gap = 1'b1;
          p_gap_pos = p_count;
        end
      end else if (last || p_count >= ipv6p_pkg::GROUPS) begin
        p_failed = 1'b1;
      end else begin
        close_group();
      end
    end else begin
      p_failed = 1'b1;
    end
  endtask

  task automatic parse_char(input ipv6p_pkg::in_t item, output logic done,
                            output ipv6p_pkg::out_t addr);
    logic [15:0] g [8];
    int p;
    int zeros;
    done = 1'b0;
    addr = '0;
    if (!p_failed) begin
      if (p_start) begin
        p_start = 1'b0;
        if (item.character == ipv6p_pkg::CHAR_COLON) begin
          if (item.is_last) p_failed = 1'b1;
          else p_lead = 1'b1;
        end else begin
          absorb_char(item.character, item.is_last);
        end
      end else if (p_lead) begin
        p_lead = 1'b0;
        if (item.character != ipv6p_pkg::CHAR_COLON) p_failed = 1'b1;
        else absorb_char(item.character, item.is_last);
      end else begin
        absorb_char(item.character, item.is_last);
      end
    end
    if (item.is_last) begin
      done = 1'b1;
      if (!p_failed && p_digits != 3'd0) begin
        if (p_count >= ipv6p_pkg::GROUPS) p_failed = 1'b1;
        else close_group();
      end
      if (!p_failed) begin
        if (p_gap) begin
          if (p_count >= ipv6p_pkg::GROUPS) p_failed = 1'b1;
        end else if (p_count != ipv6p_pkg::GROUPS) begin
          p_failed = 1'b1;
        end
      end
      if (!p_failed) begin
        p = p_gap ? int'(p_gap_pos) : int'(ipv6p_pkg::GROUPS);
        zeros = int'(ipv6p_pkg::GROUPS) - int'(p_count);
        for (int i = 0; i < 8; i++) begin
          if (i < p) g[i] = p_groups[i];
          else if (i < p + zeros) g[i] = 16'h0;
          else g[i] = p_groups[i - zeros];
        end
        addr.parse_ok = 1'b1;
        addr.addr_high = {g[0], g[1], g[2], g[3]};
        addr.addr_low = {g[4], g[5], g[6], g[7]};
      end
      clear_parse();
    end
  endtask

  task automatic send_char(ipv6p_pkg::in_t item, int idle, logic typed, logic ok);
    logic done;
    ipv6p_pkg::out_t addr;
    if (idle > 0) begin
      @(negedge clk);
      request_valid <= 1'b0;
      repeat (idle - 1) @(negedge clk);
    end
    @(negedge clk);
    request_valid <= 1'b1;
    request <= item;
    @(posedge clk);
    while (request_stall) @(posedge clk);
    parse_char(item, done, addr);
    if (done) begin
      if (typed) begin
        addr = '0;
        addr.parse_ok = ok;
      end
      pending_addrs.push_back(addr);
    end
  endtask

  task automatic emit_group();
    logic [15:0] v;
    int r;
    int lo_digits;
    int ndig;
    r = $urandom_range(0, 9);
    if (r < 2) v = 16'h0;
    else if (r < 4) v = 16'hffff;
    else v = 16'($urandom);
    lo_digits = (v >= 16'h1000) ? 4 : (v >= 16'h100) ? 3 : (v >= 16'h10) ? 2 : 1;
    ndig = $urandom_range(lo_digits, 4);
    for (int k = ndig - 1; k >= 0; k--) text_chars.push_back(hex_char(4'(v >> (4 * k))));
  endtask

  task automatic build_address(int n, logic with_gap);
    int p;
    p = with_gap ? $urandom_range(0, n) : -1;
    for (int i = 0; i < n; i++) begin
      if (i == p) begin
        text_chars.push_back(ipv6p_pkg::CHAR_COLON);
        text_chars.push_back(ipv6p_pkg::CHAR_COLON);
      end else if (i > 0) begin
        text_chars.push_back(ipv6p_pkg::CHAR_COLON);
      end
      emit_group();
    end
    if (p == n) begin
      text_chars.push_back(ipv6p_pkg::CHAR_COLON);
      text_chars.push_back(ipv6p_pkg::CHAR_COLON);
    end
  endtask

  task automatic build_valid();
    int n;
    n = $urandom_range(0, 8);
    build_address(n, n < 8);
  endtask

  task automatic build_broken();
    int kind;
    kind = $urandom_range(0, 7);
    case (kind)
      0: begin
        build_address(9, 1'b0);
      end
      1: begin
        build_address(8, 1'b1);
      end
      2: begin
        build_address($urandom_range(0, 7), 1'b1);
        text_chars.push_back(ipv6p_pkg::CHAR_COLON);
        text_chars.push_back(ipv6p_pkg::CHAR_COLON);
        text_chars.push_back(hex_char(4'($urandom)));
      end
      3: begin
        build_address($urandom_range(1, 7), 1'b1);
        text_chars.push_back(ipv6p_pkg::CHAR_COLON);
        repeat (5) text_chars.push_back(hex_char(4'($urandom)));
      end
      4: begin
        build_valid();
        text_chars.insert($urandom_range(0, text_chars.size()), 8'($urandom));
      end
      5: begin
        build_valid();
        if (text_chars.size() > 1) text_chars.delete($urandom_range(0, text_chars.size() - 1));
      end
      6: begin
        build_valid();
        text_chars.push_back(ipv6p_pkg::CHAR_COLON);
      end
      default: begin
        build_address($urandom_range(1, 7), 1'b0);
      end
    endcase
  endtask

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    if (mismatch_count < 50)
      $display("mismatch %s: got %h want %h at cycle %0d", field, got, want, cycle_count);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    ipv6p_pkg::out_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_addrs.size() == 0) begin
        report_mismatch("unexpected result", 64'(result.parse_ok), 64'h0);
      end else begin
        want = pending_addrs.pop_front();
        if (result.parse_ok !== want.parse_ok)
          report_mismatch("parse_ok", 64'(result.parse_ok), 64'(want.parse_ok));
        if (result.addr_high !== want.addr_high)
          report_mismatch("addr_high", result.addr_high, want.addr_high);
        if (result.addr_low !== want.addr_low)
          report_mismatch("addr_low", result.addr_low, want.addr_low);
      end
    end
  end

  initial begin
    int n;
    @(negedge clk);
    forever begin
      n = pick_idle();
      if (n > 0) begin
        result_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      result_stall <= 1'b0;
      repeat (($urandom_range(0, 7) == 0) ? $urandom_range(30, 100) : $urandom_range(1, 4))
        @(negedge clk);
    end
  end

  initial begin
    int total;
    int r;
    logic calm;
    ipv6p_pkg::in_t item;
    rst = 1'b1;
    request_valid = 1'b0;
    request = '0;
    result_stall = 1'b0;
    clear_parse();
    directed_rows = '{
      '{":", 1'b0, 1'b0, 1'b0}, '{":", 1'b1, 1'b1, 1'b1},
      '{":", 1'b1, 1'b1, 1'b0},
      '{":", 1'b0, 1'b0, 1'b0}, '{"1", 1'b1, 1'b1, 1'b0},
      '{"1", 1'b0, 1'b0, 1'b0}, '{"2", 1'b0, 1'b0, 1'b0}, '{"3", 1'b0, 1'b0, 1'b0},
      '{"4", 1'b0, 1'b0, 1'b0}, '{"5", 1'b1, 1'b1, 1'b0},
      '{":", 1'b0, 1'b0, 1'b0}, '{":", 1'b0, 1'b0, 1'b0}, '{":", 1'b1, 1'b1, 1'b0},
      '{"1", 1'b0, 1'b0, 1'b0}, '{":", 1'b1, 1'b1, 1'b0},
      '{"g", 1'b0, 1'b0, 1'b0}, '{"A", 1'b1, 1'b1, 1'b0},
      '{8'hff, 1'b1, 1'b1, 1'b0},
      '{8'h00, 1'b1, 1'b1, 1'b0},
      '{"F", 1'b1, 1'b1, 1'b0},
      '{"f", 1'b0, 1'b0, 1'b0}, '{"A", 1'b0, 1'b0, 1'b0}, '{":", 1'b0, 1'b0, 1'b0},
      '{":", 1'b1, 1'b0, 1'b0}
    };
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      item.character = directed_rows[i].ch;
      item.is_last = directed_rows[i].last;
      send_char(item, pick_idle(), directed_rows[i].typed, directed_rows[i].ok);
    end

    total = 0;
    while (total < TARGET_CHARS) begin
      text_chars.delete();
      r = $urandom_range(0, 99);
      if (r < 60) begin
        build_valid();
      end else if (r < 90) begin
        build_broken();
      end else begin
        repeat ($urandom_range(1, 6)) text_chars.push_back(8'($urandom));
      end
      calm = ($urandom_range(0, 4) == 0);
      foreach (text_chars[i]) begin
        item.character = text_chars[i];
        item.is_last = (i == text_chars.size() - 1);
        send_char(item, calm ? 0 : pick_idle(), 1'b0, 1'b0);
      end
      total += text_chars.size();
    end
    @(negedge clk);
    request_valid <= 1'b0;

    while (pending_addrs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_addrs.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/ipv6p_pkg.sv
rtl/ipv6p_input_stage.sv
rtl/ipv6p_parser.sv
rtl/ipv6p_assembler.sv
rtl/ipv6_text_address_parser.sv
sim/testbench.sv
